### rtl/bipd_pkg.sv
package bipd_pkg;

    // Default width of the tick counter and of the best-time register.
    localparam int TIME_WIDTH_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TIME_OUT_W = 16;
    localparam int VEC_W      = 3;
    localparam int DRV_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_TICKS    = 2'd1;

    localparam logic [CFG_DATA_W-1:0] TIMEOUT_RESET = 16'd6000;
    localparam logic [CFG_DATA_W-1:0] REST_RESET    = 16'd6000;
    localparam int                    BEST_RESET    = 6000;

    localparam logic [VEC_W-1:0] VEC_FIRST = 3'd0;
    localparam logic [VEC_W-1:0] VEC_LAST  = 3'd5;

    localparam logic [DRV_W-1:0] DRV_OFF  = 2'b00;
    localparam logic [DRV_W-1:0] DRV_LOW  = 2'b01;
    localparam logic [DRV_W-1:0] DRV_HIGH = 2'b10;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_PULSE = 2'd1,
        MODE_REST  = 2'd2
    } t_mode;

    typedef struct packed {
        logic start_req;
        logic comparator_trip;
    } t_in_item;

    typedef struct packed {
        logic [DRV_W-1:0]      drive_u;
        logic [DRV_W-1:0]      drive_v;
        logic [DRV_W-1:0]      drive_w;
        logic                  adc_trigger;
        logic                  busy_res;
        logic                  done_res;
        logic [VEC_W-1:0]      detected_vector;
        logic [TIME_OUT_W-1:0] shortest_time;
    } t_out_item;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] pulse_timeout;
        logic [CFG_DATA_W-1:0] rest_ticks;
    } t_cfg;

    typedef struct packed {
        logic [DRV_W-1:0] u;
        logic [DRV_W-1:0] v;
        logic [DRV_W-1:0] w;
    } t_drive;

    // Phase drive for each test vector: first phase high, second phase low.
    function automatic t_drive drive_of(input logic [VEC_W-1:0] vec);
        t_drive d;
        case (vec)
            3'd0:    d = '{u: DRV_HIGH, v: DRV_LOW,  w: DRV_OFF};
            3'd1:    d = '{u: DRV_HIGH, v: DRV_OFF,  w: DRV_LOW};
            3'd2:    d = '{u: DRV_LOW,  v: DRV_HIGH, w: DRV_OFF};
            3'd3:    d = '{u: DRV_OFF,  v: DRV_HIGH, w: DRV_LOW};
            3'd4:    d = '{u: DRV_LOW,  v: DRV_OFF,  w: DRV_HIGH};
            3'd5:    d = '{u: DRV_OFF,  v: DRV_LOW,  w: DRV_HIGH};
            default: d = '{u: DRV_OFF,  v: DRV_OFF,  w: DRV_OFF};
        endcase
        return d;
    endfunction

endpackage

### rtl/bldc_initial_position_detector_top.sv
// Inductive initial rotor position detector for a BLDC motor. Each input item is one timer
// tick carrying a start request and the current-comparator trip; each accepted item yields
// exactly one result item with the phase drives, ADC trigger, busy and done flags, and the
// winning vector with its time. A start while idle runs six test pulses (U-V, U-W, V-U,
// V-W, W-U, W-V), each followed by a rest with all drives off. The block takes one item
// per clock cycle while the result side does not stall; a result is offered once its item
// has passed the input register and the sequencer step that reads it has loaded the result
// register. Stall on the result side holds both registers and reaches the input stall in
// the same cycle once the input register is occupied. The configuration registers take a
// write at any edge, so write them only while no item is in flight.
module bldc_initial_position_detector_top #(
    parameter int TIME_WIDTH = bipd_pkg::TIME_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  bipd_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output bipd_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_we,
    input  logic [bipd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bipd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    bipd_pkg::t_cfg       cfg;
    bipd_pkg::t_out_item  step_result;

    logic                 r_s1_valid;
    bipd_pkg::t_in_item   r_s1_item;
    logic                 r_out_valid;
    bipd_pkg::t_out_item  r_out_item;
    logic                 advance;
    logic                 in_accept;

    assign advance    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    bipd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bipd_sequencer #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_s1_item),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### rtl/bipd_cfg_regs.sv
module bipd_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bipd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bipd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output bipd_pkg::t_cfg                    o_cfg
);

    logic [bipd_pkg::CFG_DATA_W-1:0] r_pulse_timeout;
    logic [bipd_pkg::CFG_DATA_W-1:0] r_rest_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_timeout <= bipd_pkg::TIMEOUT_RESET;
            r_rest_ticks    <= bipd_pkg::REST_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bipd_pkg::CFG_PULSE_TIMEOUT: r_pulse_timeout <= i_cfg_data;
                bipd_pkg::CFG_REST_TICKS:    r_rest_ticks    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.pulse_timeout = r_pulse_timeout;
    assign o_cfg.rest_ticks    = r_rest_ticks;

endmodule

### rtl/bipd_sequencer.sv
module bipd_sequencer #(
    parameter int TIME_WIDTH = bipd_pkg::TIME_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  bipd_pkg::t_in_item   i_item,
    input  bipd_pkg::t_cfg       i_cfg,
    output bipd_pkg::t_out_item  o_result
);

    // Compare width covers both the counter and the 16-bit registers.
    localparam int CMP_W = (TIME_WIDTH > bipd_pkg::CFG_DATA_W) ?
                           TIME_WIDTH : bipd_pkg::CFG_DATA_W;
    localparam longint TMAX_L = (64'd1 << TIME_WIDTH) - 64'd1;
    localparam logic [TIME_WIDTH-1:0] TMAX = TIME_WIDTH'(TMAX_L);
    localparam logic [TIME_WIDTH-1:0] BEST_RST =
        TIME_WIDTH'((64'(bipd_pkg::BEST_RESET) > TMAX_L) ?
                    TMAX_L : 64'(bipd_pkg::BEST_RESET));

    bipd_pkg::t_mode               r_mode, n_mode;
    logic [bipd_pkg::VEC_W-1:0]    r_vec, n_vec;
    logic [TIME_WIDTH-1:0]         r_tick, n_tick;
    logic [TIME_WIDTH-1:0]         r_best_time, n_best_time;
    logic [bipd_pkg::VEC_W-1:0]    r_best_vec, n_best_vec;

    bipd_pkg::t_mode               cur_mode;
    logic [bipd_pkg::VEC_W-1:0]    cur_vec;
    logic [TIME_WIDTH-1:0]         cur_tick;
    logic [TIME_WIDTH-1:0]         cur_best;
    logic [TIME_WIDTH-1:0]         tick_inc;
    logic [TIME_WIDTH-1:0]         timeout_sat;
    logic [CMP_W-1:0]              timeout_ext;
    logic [CMP_W-1:0]              rest_ext;
    logic [CMP_W-1:0]              inc_ext;
    logic [CMP_W-1:0]              best_ext;
    logic                          at_max;
    bipd_pkg::t_drive              drv;
    logic                          adc, busy, done;

    always_comb begin
        timeout_ext = CMP_W'(i_cfg.pulse_timeout);
        rest_ext    = CMP_W'(i_cfg.rest_ticks);
        // Timeout loaded into best time saturates to the counter range.
        if (timeout_ext > CMP_W'(TMAX)) begin
            timeout_sat = TMAX;
        end else begin
            timeout_sat = TIME_WIDTH'(timeout_ext);
        end

        cur_mode = r_mode;
        cur_vec  = (r_vec > bipd_pkg::VEC_LAST) ? bipd_pkg::VEC_FIRST : r_vec;
        cur_tick = r_tick;
        cur_best = r_best_time;
        if (r_mode == bipd_pkg::MODE_IDLE && i_item.start_req) begin
            cur_mode = bipd_pkg::MODE_PULSE;
            cur_vec  = bipd_pkg::VEC_FIRST;
            cur_tick = '0;
            cur_best = timeout_sat;
        end

        tick_inc = (cur_tick != TMAX) ? cur_tick + 1'b1 : cur_tick;
        inc_ext  = CMP_W'(tick_inc);
        at_max   = (tick_inc == TMAX);

        n_mode      = cur_mode;
        n_vec       = cur_vec;
        n_tick      = cur_tick;
        n_best_time = cur_best;
        n_best_vec  = r_best_vec;
        drv         = bipd_pkg::drive_of(cur_vec);
        adc         = 1'b0;
        busy        = 1'b0;
        done        = 1'b0;

        case (cur_mode)
            bipd_pkg::MODE_PULSE: begin
                adc    = 1'b1;
                busy   = 1'b1;
                n_tick = tick_inc;
                if (i_item.comparator_trip || inc_ext >= timeout_ext || at_max) begin
                    // Ties go to the later vector.
                    if (cur_best >= tick_inc) begin
                        n_best_time = tick_inc;
                        n_best_vec  = cur_vec;
                    end
                    n_mode = bipd_pkg::MODE_REST;
                    n_tick = '0;
                end
            end
            bipd_pkg::MODE_REST: begin
                drv    = '{u: bipd_pkg::DRV_OFF, v: bipd_pkg::DRV_OFF,
                           w: bipd_pkg::DRV_OFF};
                busy   = 1'b1;
                n_tick = tick_inc;
                if (inc_ext >= rest_ext || at_max) begin
                    n_tick = '0;
                    if (cur_vec >= bipd_pkg::VEC_LAST) begin
                        done   = 1'b1;
                        n_mode = bipd_pkg::MODE_IDLE;
                        n_vec  = bipd_pkg::VEC_FIRST;
                    end else begin
                        n_vec  = cur_vec + 1'b1;
                        n_mode = bipd_pkg::MODE_PULSE;
                    end
                end
            end
            default: begin
                n_mode = bipd_pkg::MODE_IDLE;
                drv    = '{u: bipd_pkg::DRV_OFF, v: bipd_pkg::DRV_OFF,
                           w: bipd_pkg::DRV_OFF};
            end
        endcase

        best_ext                 = CMP_W'(n_best_time);
        o_result.drive_u         = drv.u;
        o_result.drive_v         = drv.v;
        o_result.drive_w         = drv.w;
        o_result.adc_trigger     = adc;
        o_result.busy_res        = busy;
        o_result.done_res        = done;
        o_result.detected_vector = n_best_vec;
        o_result.shortest_time   = best_ext[bipd_pkg::TIME_OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= bipd_pkg::MODE_IDLE;
            r_vec       <= bipd_pkg::VEC_FIRST;
            r_tick      <= '0;
            r_best_time <= BEST_RST;
            r_best_vec  <= bipd_pkg::VEC_FIRST;
        end else if (i_step) begin
            r_mode      <= n_mode;
            r_vec       <= n_vec;
            r_tick      <= n_tick;
            r_best_time <= n_best_time;
            r_best_vec  <= n_best_vec;
        end
    end

endmodule

### verif/tb_bldc_initial_position_detector_top.sv
`timescale 1ns / 100ps

module tb_bldc_initial_position_detector_top;
    import bipd_pkg::*;

    localparam int TW = TIME_WIDTH_DEF;
    localparam logic [TW-1:0] TICK_MAX = {TW{1'b1}};

    localparam int unsigned RUN_LIMIT = 200_000;
    localparam int SETTLE_LIMIT  = 2000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int HOLD_CYCLES   = 150;
    localparam int ITEM_TARGET   = 1300;

    localparam int PH_U = 0;
    localparam int PH_V = 1;
    localparam int PH_W = 2;

    // Index values beyond the two defined registers; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // Marks "no vector" when choosing which pulse runs without a trip.
    localparam logic [VEC_W-1:0] NO_VEC = 3'd7;

    localparam t_out_item OUT_AT_RESET = '{drive_u: DRV_OFF, drive_v: DRV_OFF, drive_w: DRV_OFF,
        adc_trigger: 1'b0, busy_res: 1'b0, done_res: 1'b0, detected_vector: VEC_FIRST,
        shortest_time: 16'd6000};
    localparam t_out_item OUT_FIRST_TRIP = '{drive_u: DRV_HIGH, drive_v: DRV_LOW,
        drive_w: DRV_OFF, adc_trigger: 1'b1, busy_res: 1'b1, done_res: 1'b0,
        detected_vector: VEC_FIRST, shortest_time: 16'd1};
    localparam t_out_item OUT_FIRST_REST = '{drive_u: DRV_OFF, drive_v: DRV_OFF,
        drive_w: DRV_OFF, adc_trigger: 1'b0, busy_res: 1'b1, done_res: 1'b0,
        detected_vector: VEC_FIRST, shortest_time: 16'd1};
    localparam t_out_item OUT_ALL_TIED = '{drive_u: DRV_OFF, drive_v: DRV_OFF, drive_w: DRV_OFF,
        adc_trigger: 1'b0, busy_res: 1'b0, done_res: 1'b0, detected_vector: VEC_LAST,
        shortest_time: 16'd1};

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_CFG,
        ROW_RUN
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        t_in_item              it;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [VEC_W-1:0]      slow;
        logic                  typed;
        t_out_item             want;
    } t_row;

    typedef enum logic [1:0] {
        ST_NONE,
        ST_RANDOM,
        ST_SPARSE,
        ST_DENSE
    } t_stall_pat;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_item = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow of the detector sequencer and its registers.
    t_mode                 sq_mode;
    logic [VEC_W-1:0]      sq_vec;
    logic [TW-1:0]         sq_ticks;
    logic [TW-1:0]         win_time;
    logic [VEC_W-1:0]      win_vec;
    logic [CFG_DATA_W-1:0] lim_pulse;
    logic [CFG_DATA_W-1:0] lim_rest;

    t_out_item due_results[$];
    t_row      stim_tab[$];
    int        n_err = 0;
    int        n_sent = 0;
    int        burst_left = 0;
    bit        quiet = 1'b0;
    bit        hold_req = 1'b0;
    bit        hold_done = 1'b0;

    bldc_initial_position_detector_top #(
        .TIME_WIDTH(TW)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // One timer tick of the detector: returns the drives and status shown for this tick.
    function automatic t_out_item step_detector(input t_in_item it);
        t_out_item        r;
        logic [DRV_W-1:0] dr [3];
        int               hi;
        int               lo;
        int               p;
        r = '0;
        if (sq_mode == MODE_IDLE && it.start_req) begin
            sq_mode  = MODE_PULSE;
            sq_vec   = VEC_FIRST;
            sq_ticks = '0;
            win_time = lim_pulse;
        end
        if (sq_mode == MODE_PULSE) begin
            // Vectors go in pairs by high phase; the low phase is the lower of the
            // other two for even vectors and the upper one for odd vectors.
            hi = int'(sq_vec >> 1);
            if (sq_vec[0])
                lo = (hi == PH_W) ? PH_V : PH_W;
            else
                lo = (hi == PH_U) ? PH_V : PH_U;
            for (p = PH_U; p <= PH_W; p++)
                dr[p] = (p == hi) ? DRV_HIGH : ((p == lo) ? DRV_LOW : DRV_OFF);
            r.drive_u     = dr[PH_U];
            r.drive_v     = dr[PH_V];
            r.drive_w     = dr[PH_W];
            r.adc_trigger = 1'b1;
            r.busy_res    = 1'b1;
            if (sq_ticks != TICK_MAX)
                sq_ticks++;
            if (it.comparator_trip || sq_ticks >= lim_pulse || sq_ticks == TICK_MAX) begin
                if (win_time >= sq_ticks) begin
                    win_time = sq_ticks;
                    win_vec  = sq_vec;
                end
                sq_mode  = MODE_REST;
                sq_ticks = '0;
            end
        end else if (sq_mode == MODE_REST) begin
            r.busy_res = 1'b1;
            if (sq_ticks != TICK_MAX)
                sq_ticks++;
            if (sq_ticks >= lim_rest || sq_ticks == TICK_MAX) begin
                sq_ticks = '0;
                if (sq_vec >= VEC_LAST) begin
                    r.done_res = 1'b1;
                    sq_mode    = MODE_IDLE;
                    sq_vec     = VEC_FIRST;
                end else begin
                    sq_vec  = sq_vec + 1'b1;
                    sq_mode = MODE_PULSE;
                end
            end
        end
        r.detected_vector = win_vec;
        r.shortest_time   = win_time[TIME_OUT_W-1:0];
        return r;
    endfunction

    task automatic cmp_field(input string name, input logic [15:0] e, input logic [15:0] a);
        if (a !== e) begin
            n_err++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, e, a);
        end
    endtask

    always @(posedge clk) begin : result_check
        t_out_item w;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (due_results.size() == 0) begin
                n_err++;
                $display("%0t ns: unexpected result, expected none, got %p", $time,
                         out_item);
            end else begin
                w = due_results.pop_front();
                cmp_field("drive_u", w.drive_u, out_item.drive_u);
                cmp_field("drive_v", w.drive_v, out_item.drive_v);
                cmp_field("drive_w", w.drive_w, out_item.drive_w);
                cmp_field("adc_trigger", w.adc_trigger, out_item.adc_trigger);
                cmp_field("busy_res", w.busy_res, out_item.busy_res);
                cmp_field("done_res", w.done_res, out_item.done_res);
                cmp_field("detected_vector", w.detected_vector, out_item.detected_vector);
                cmp_field("shortest_time", w.shortest_time, out_item.shortest_time);
            end
        end
    end

    // Result-side back-pressure: segments of differing stall patterns, plus one long hold.
    initial begin : stall_gen
        int         seg;
        int         pct;
        int         per;
        int         k;
        t_stall_pat pat;
        forever begin
            seg = $urandom_range(10, 200);
            pat = t_stall_pat'($urandom_range(0, 3));
            pct = $urandom_range(10, 70);
            per = $urandom_range(2, 7);
            for (k = 0; k < seg; k++) begin
                @(posedge clk);
                if (hold_req && !hold_done) begin
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_done = 1'b1;
                end
                if (quiet)
                    out_stall <= 1'b0;
                else begin
                    case (pat)
                        ST_NONE:   out_stall <= 1'b0;
                        ST_RANDOM: out_stall <= ($urandom_range(0, 99) < pct);
                        ST_SPARSE: out_stall <= (k % per == 0);
                        default:   out_stall <= (k % per != 0);
                    endcase
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("[bldc_initial_position_detector_top] ERROR");
        $finish;
    end

    task automatic offer(input t_in_item it, input logic typed, input t_out_item want);
        int        gap;
        t_out_item got;
        if (!quiet && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_sent++;
        got = step_detector(it);
        due_results.push_back(typed ? want : got);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Feeds plain ticks until the run is over; every pulse trips at once except the slow one.
    task automatic finish_run(input logic [VEC_W-1:0] slow);
        t_in_item it;
        while (sq_mode != MODE_IDLE) begin
            it.start_req       = 1'b0;
            it.comparator_trip = !(sq_mode == MODE_PULSE && sq_vec == slow);
            offer(it, 1'b0, '0);
        end
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (due_results.size() != 0 && waited < SETTLE_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (due_results.size() != 0) begin
            n_err++;
            $display("%0t ns: missing results, expected %0d more, got none", $time,
                     due_results.size());
            due_results.delete();
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_PULSE_TIMEOUT)
            lim_pulse = data;
        else if (idx == CFG_REST_TICKS)
            lim_rest = data;
    endtask

    task automatic add_item(input logic start, input logic trip, input logic typed,
                            input t_out_item want);
        t_row r;
        r       = '0;
        r.kind  = ROW_ITEM;
        r.it    = '{start_req: start, comparator_trip: trip};
        r.typed = typed;
        r.want  = want;
        stim_tab.push_back(r);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        t_row r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        stim_tab.push_back(r);
    endtask

    task automatic add_run(input logic [VEC_W-1:0] slow);
        t_row r;
        r      = '0;
        r.kind = ROW_RUN;
        r.slow = slow;
        stim_tab.push_back(r);
    endtask

    initial begin : main
        t_in_item              it;
        int                    k;
        int                    n;
        int                    start_pct;
        int                    trip_pct;
        int                    phase;
        logic [CFG_DATA_W-1:0] t_val;
        logic [CFG_DATA_W-1:0] r_val;

        sq_mode   = MODE_IDLE;
        sq_vec    = VEC_FIRST;
        sq_ticks  = '0;
        win_time  = TW'(BEST_RESET);
        win_vec   = VEC_FIRST;
        lim_pulse = TIMEOUT_RESET;
        lim_rest  = REST_RESET;

        // Reset settings: idle output, a trip on the first tick, a start while busy,
        // then a short rest so the run finishes quickly; six one-tick pulses all tie,
        // so the last vector wins.
        add_item(1'b0, 1'b0, 1'b1, OUT_AT_RESET);
        add_item(1'b0, 1'b1, 1'b1, OUT_AT_RESET);
        add_item(1'b1, 1'b1, 1'b1, OUT_FIRST_TRIP);
        add_item(1'b1, 1'b0, 1'b1, OUT_FIRST_REST);
        add_cfg(CFG_REST_TICKS, 16'd2);
        add_run(NO_VEC);
        add_item(1'b0, 1'b0, 1'b1, OUT_ALL_TIED);
        // Writes past the register list, then zero timeout and zero rest.
        add_cfg(CFG_SPARE_A, 16'hA5A5);
        add_cfg(CFG_SPARE_B, 16'h5A5A);
        add_cfg(CFG_PULSE_TIMEOUT, 16'd0);
        add_cfg(CFG_REST_TICKS, 16'd0);
        add_item(1'b1, 1'b0, 1'b0, '0);
        add_item(1'b0, 1'b1, 1'b0, '0);
        add_item(1'b1, 1'b1, 1'b0, '0);
        add_run(NO_VEC);
        // Largest timeout with a short rest, then one pulse that runs into a longer timeout.
        add_cfg(CFG_PULSE_TIMEOUT, 16'hFFFF);
        add_cfg(CFG_REST_TICKS, 16'd2);
        add_item(1'b1, 1'b1, 1'b0, '0);
        add_run(NO_VEC);
        add_cfg(CFG_PULSE_TIMEOUT, 16'd150);
        add_item(1'b1, 1'b1, 1'b0, '0);
        add_run(3'd3);
        add_cfg(CFG_PULSE_TIMEOUT, 16'd1);
        add_cfg(CFG_REST_TICKS, 16'd1);
        add_item(1'b1, 1'b0, 1'b0, '0);
        add_item(1'b0, 1'b0, 1'b0, '0);
        add_item(1'b0, 1'b1, 1'b0, '0);
        add_run(NO_VEC);
        // A trip on the same tick that reaches the timeout.
        add_cfg(CFG_PULSE_TIMEOUT, 16'd3);
        add_cfg(CFG_REST_TICKS, 16'd2);
        add_item(1'b1, 1'b0, 1'b0, '0);
        add_item(1'b0, 1'b0, 1'b0, '0);
        add_item(1'b0, 1'b1, 1'b0, '0);
        add_run(NO_VEC);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_tab[i]) begin
            case (stim_tab[i].kind)
                ROW_ITEM: offer(stim_tab[i].it, stim_tab[i].typed, stim_tab[i].want);
                ROW_CFG: begin
                    settle();
                    write_reg(stim_tab[i].idx, stim_tab[i].data);
                end
                default: begin
                    quiet = 1'b1;
                    finish_run(stim_tab[i].slow);
                    quiet = 1'b0;
                end
            endcase
        end

        phase = 0;
        while (n_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 5))
                0:       t_val = 16'd0;
                1:       t_val = 16'd1;
                2, 3:    t_val = CFG_DATA_W'($urandom_range(2, 12));
                default: t_val = CFG_DATA_W'($urandom_range(13, 60));
            endcase
            case ($urandom_range(0, 3))
                0:       r_val = 16'd0;
                1:       r_val = 16'd1;
                default: r_val = CFG_DATA_W'($urandom_range(2, 8));
            endcase
            settle();
            write_reg(CFG_PULSE_TIMEOUT, t_val);
            write_reg(CFG_REST_TICKS, r_val);
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          CFG_DATA_W'($urandom));
            case ($urandom_range(0, 4))
                0:       trip_pct = 0;
                1:       trip_pct = 100;
                2:       trip_pct = $urandom_range(2, 15);
                3:       trip_pct = $urandom_range(20, 50);
                default: trip_pct = $urandom_range(60, 90);
            endcase
            start_pct = $urandom_range(5, 60);
            n = $urandom_range(80, 220);
            for (k = 0; k < n && n_sent < ITEM_TARGET; k++) begin
                it.start_req       = ($urandom_range(0, 99) < start_pct);
                it.comparator_trip = ($urandom_range(0, 99) < trip_pct);
                // Hold the result side while items keep coming so the block backs up.
                if (phase == 1 && k == 20)
                    hold_req = 1'b1;
                offer(it, 1'b0, '0);
            end
            finish_run(NO_VEC);
            phase++;
        end

        settle();
        if (n_err == 0)
            $display("[bldc_initial_position_detector_top] OK");
        else
            $display("[bldc_initial_position_detector_top] ERROR");
        $finish;
    end

endmodule

### bldc_initial_position_detector_top.f
rtl/bipd_pkg.sv
rtl/bipd_cfg_regs.sv
rtl/bipd_sequencer.sv
rtl/bldc_initial_position_detector_top.sv
verif/tb_bldc_initial_position_detector_top.sv
